>>> hw/rtl/rpc_pkg.sv
// ----------------------------------------------------------------------------
// rpc_pkg
// shared types and constants of the rectangle pair cipher: grid geometry,
// action codes, grid and lookup types
// ----------------------------------------------------------------------------
package rpc_pkg;

    localparam int GRID_ROWS  = 9;
    localparam int GRID_COLS  = 6;
    localparam int GRID_CELLS = GRID_ROWS * GRID_COLS;

    localparam int CHAR_W     = 8;
    localparam int KEY_IDX_W  = 6;

    typedef enum logic {
        ACT_KEY_LOAD = 1'b0,
        ACT_ENCRYPT  = 1'b1
    } action_t;

    typedef logic [GRID_CELLS-1:0][CHAR_W-1:0] grid_t;
    typedef logic [GRID_COLS-1:0][CHAR_W-1:0]  row_t;

    // result of looking up one character in the grid
    typedef struct packed {
        logic                 found;
        logic [GRID_ROWS-1:0] row_oh;
        logic [GRID_COLS-1:0] col_oh;
        row_t                 row_data;
    } loc_t;

endpackage

>>> hw/rtl/rpc_locate.sv
// ----------------------------------------------------------------------------
// rpc_locate
// finds the first row-major grid entry equal to a character and returns its
// row and column as one-hot vectors together with the whole matching row
// ----------------------------------------------------------------------------
module rpc_locate (
    input  rpc_pkg::grid_t                grid,
    input  logic [rpc_pkg::CHAR_W-1:0]    ch,
    output rpc_pkg::loc_t                 loc
);
    import rpc_pkg::*;

    logic [GRID_CELLS-1:0] match;
    logic [GRID_ROWS-1:0]  row_any;
    logic [GRID_ROWS-1:0]  row_oh;
    logic [GRID_COLS-1:0]  col_match;
    logic [GRID_COLS-1:0]  col_oh;
    row_t                  row_data;

    always_comb begin
        logic row_seen;
        logic col_seen;
        row_seen  = 1'b0;
        col_seen  = 1'b0;
        row_oh    = '0;
        col_oh    = '0;
        col_match = '0;
        row_data  = '0;
        for (int i = 0; i < GRID_CELLS; i++) begin
            match[i] = (grid[i] == ch);
        end
        for (int r = 0; r < GRID_ROWS; r++) begin
            row_any[r] = |match[r*GRID_COLS +: GRID_COLS];
        end
        // first row holding a match
        for (int r = 0; r < GRID_ROWS; r++) begin
            row_oh[r] = row_any[r] && !row_seen;
            row_seen  = row_seen | row_any[r];
        end
        for (int r = 0; r < GRID_ROWS; r++) begin
            if (row_oh[r]) begin
                row_data  = row_data | grid[r*GRID_COLS +: GRID_COLS];
                col_match = col_match | match[r*GRID_COLS +: GRID_COLS];
            end
        end
        // first column within that row
        for (int c = 0; c < GRID_COLS; c++) begin
            col_oh[c] = col_match[c] && !col_seen;
            col_seen  = col_seen | col_match[c];
        end
    end

    assign loc.found    = |row_any;
    assign loc.row_oh   = row_oh;
    assign loc.col_oh   = col_oh;
    assign loc.row_data = row_data;

endmodule

>>> hw/rtl/rectangle_pair_cipher.sv
// ----------------------------------------------------------------------------
// rectangle_pair_cipher
// digraph substitution over a key grid held in flip-flops
// ----------------------------------------------------------------------------
// One request per cycle is accepted unless stalled, key loads and character
// pairs alike. A key load writes one grid entry in the cycle it is accepted
// and gives no result; an index beyond the grid is dropped. A pair passes
// through an input register, a lookup stage that compares both characters
// against every grid entry in parallel and keeps the first row-major match,
// and a column select into the output register. The grid has no reset and
// must be fully loaded before the first pair is sent.
// ----------------------------------------------------------------------------
module rectangle_pair_cipher (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    // key_index[5:0], key_char[13:6], first_char[21:14], second_char[29:22]
    input  logic [31:0] s_tdata,
    // action[0], lone[1]
    input  logic [1:0]  s_tuser,

    output logic        m_tvalid,
    input  logic        m_tready,
    // out_first[7:0], out_second[15:8]
    output logic [15:0] m_tdata,
    // substituted[0]
    output logic        m_tuser
);
    import rpc_pkg::*;

    logic                 in_ready;
    logic                 mid_ready;
    logic                 out_ready;
    logic                 s_accept;
    action_t              s_action;

    logic [KEY_IDX_W-1:0] s_key_index;
    logic [CHAR_W-1:0]    s_key_char;

    grid_t                grid_reg;
    grid_t                grid_next;

    logic                 in_vld_reg;
    logic [CHAR_W-1:0]    in_a_reg;
    logic [CHAR_W-1:0]    in_b_reg;
    logic                 in_lone_reg;

    loc_t                 loc_a;
    loc_t                 loc_b;
    logic                 subst_next;

    logic                 mid_vld_reg;
    logic [CHAR_W-1:0]    mid_a_reg;
    logic [CHAR_W-1:0]    mid_b_reg;
    logic                 mid_lone_reg;
    logic                 mid_subst_reg;
    row_t                 mid_row_a_reg;
    row_t                 mid_row_b_reg;
    logic [GRID_COLS-1:0] mid_col_a_reg;
    logic [GRID_COLS-1:0] mid_col_b_reg;

    logic [CHAR_W-1:0]    out_first_next;
    logic [CHAR_W-1:0]    out_second_next;

    logic                 out_vld_reg;
    logic [CHAR_W-1:0]    out_first_reg;
    logic [CHAR_W-1:0]    out_second_reg;
    logic                 out_subst_reg;

    // handshake and pipeline advance
    assign out_ready   = !out_vld_reg || m_tready;
    assign mid_ready   = !mid_vld_reg || out_ready;
    assign in_ready    = !in_vld_reg || mid_ready;
    assign s_tready    = in_ready;
    assign s_accept    = s_tvalid && in_ready;
    assign s_action    = action_t'(s_tuser[0]);
    assign s_key_index = s_tdata[KEY_IDX_W-1:0];
    assign s_key_char  = s_tdata[KEY_IDX_W +: CHAR_W];

    // key grid writes
    always_comb begin
        grid_next = grid_reg;
        if (s_accept && s_action == ACT_KEY_LOAD) begin
            for (int i = 0; i < GRID_CELLS; i++) begin
                if (32'(s_key_index) == i) begin
                    grid_next[i] = s_key_char;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        grid_reg <= grid_next;
    end

    // lookup of both characters
    rpc_locate u_locate_a (
        .grid (grid_reg),
        .ch   (in_a_reg),
        .loc  (loc_a)
    );

    rpc_locate u_locate_b (
        .grid (grid_reg),
        .ch   (in_b_reg),
        .loc  (loc_b)
    );

    assign subst_next = !in_lone_reg && loc_a.found && loc_b.found
                        && (loc_a.row_oh != loc_b.row_oh)
                        && (loc_a.col_oh != loc_b.col_oh);

    // column select
    always_comb begin
        logic [CHAR_W-1:0] sel_first;
        logic [CHAR_W-1:0] sel_second;
        sel_first  = '0;
        sel_second = '0;
        for (int c = 0; c < GRID_COLS; c++) begin
            if (mid_col_b_reg[c]) begin
                sel_first = sel_first | mid_row_a_reg[c];
            end
            if (mid_col_a_reg[c]) begin
                sel_second = sel_second | mid_row_b_reg[c];
            end
        end
        priority if (mid_subst_reg) begin
            out_first_next  = sel_first;
            out_second_next = sel_second;
        end else if (mid_lone_reg) begin
            out_first_next  = mid_a_reg;
            out_second_next = '0;
        end else begin
            out_first_next  = mid_b_reg;
            out_second_next = mid_a_reg;
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            mid_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                in_vld_reg <= s_tvalid && (s_action == ACT_ENCRYPT);
            end
            if (mid_ready) begin
                mid_vld_reg <= in_vld_reg;
            end
            if (out_ready) begin
                out_vld_reg <= mid_vld_reg;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_a_reg    <= s_tdata[KEY_IDX_W + CHAR_W +: CHAR_W];
            in_b_reg    <= s_tdata[KEY_IDX_W + 2*CHAR_W +: CHAR_W];
            in_lone_reg <= s_tuser[1];
        end
        if (mid_ready) begin
            mid_a_reg     <= in_a_reg;
            mid_b_reg     <= in_b_reg;
            mid_lone_reg  <= in_lone_reg;
            mid_subst_reg <= subst_next;
            mid_row_a_reg <= loc_a.row_data;
            mid_row_b_reg <= loc_b.row_data;
            mid_col_a_reg <= loc_a.col_oh;
            mid_col_b_reg <= loc_b.col_oh;
        end
        if (out_ready) begin
            out_first_reg  <= out_first_next;
            out_second_reg <= out_second_next;
            out_subst_reg  <= mid_subst_reg;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {out_second_reg, out_first_reg};
    assign m_tuser  = out_subst_reg;

    // checks
    a_stall_means_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> in_vld_reg && mid_vld_reg && out_vld_reg && !m_tready)
        else $error("input stalled with a free pipeline slot");

    a_in_to_mid: assert property (@(posedge aclk) disable iff (!aresetn)
        in_vld_reg && mid_ready |=> mid_vld_reg)
        else $error("pair lost between input and lookup stage");

    a_mid_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        mid_vld_reg && out_ready |=> out_vld_reg && (m_tuser == $past(mid_subst_reg)))
        else $error("pair lost or altered between lookup and output stage");

    a_subst_cols: assert property (@(posedge aclk) disable iff (!aresetn)
        mid_vld_reg && mid_subst_reg |->
            $onehot(mid_col_a_reg) && $onehot(mid_col_b_reg)
            && (mid_col_a_reg != mid_col_b_reg) && !mid_lone_reg)
        else $error("rectangle rule taken without two distinct columns");

    a_lone_out: assert property (@(posedge aclk) disable iff (!aresetn)
        mid_vld_reg && mid_lone_reg && out_ready |=> (m_tdata[15:8] == '0) && !m_tuser)
        else $error("lone character result carries a second character");

endmodule
